>>> design/idle_timeout_table_core_macros.svh
// ----------------------------------------------------------------------------
// idle_timeout_table_core_macros.svh
// Assertion shorthands for the checker of the idle timeout table.
// ----------------------------------------------------------------------------
`ifndef IDLE_TIMEOUT_TABLE_CORE_MACROS_SVH
`define IDLE_TIMEOUT_TABLE_CORE_MACROS_SVH

// clocked property, quiet while reset is asserted
`define ITT_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// clocked property, checked during reset as well
`define ITT_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> design/itt_pkg.sv
// ----------------------------------------------------------------------------
// itt_pkg
// Types, codes and sizes shared by the idle timeout table modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package itt_pkg;

	localparam int DEPTH  = 32;
	localparam int LIVE_W = $clog2(DEPTH + 1);
	localparam int IDX_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	localparam logic [15:0] TIMEOUT_RESET = 16'd1000;

	localparam logic [1:0] OP_ADD    = 2'd0;
	localparam logic [1:0] OP_TOUCH  = 2'd1;
	localparam logic [1:0] OP_REMOVE = 2'd2;
	localparam logic [1:0] OP_TICK   = 2'd3;

	localparam logic [2:0] ST_DONE      = 3'd0;
	localparam logic [2:0] ST_EXPIRED   = 3'd1;
	localparam logic [2:0] ST_NOT_FOUND = 3'd2;
	localparam logic [2:0] ST_FULL      = 3'd3;
	localparam logic [2:0] ST_TICK_DONE = 3'd4;

	typedef struct packed {
		logic [1:0]  operation;
		logic [15:0] conn_id;
	} in_item_t;

	typedef struct packed {
		logic [2:0]  status;
		logic [15:0] result_id;
		logic [5:0]  entries_in_use;
		logic        last;
	} out_item_t;

	// what one cell hands to its lower neighbor
	typedef struct packed {
		logic [15:0] id;
		logic [15:0] cnt;
		logic        any_hit;  // a match at this index or above
	} itt_link_t;

	// broadcast from the sequencer to every cell
	typedef struct packed {
		logic              search_clr;
		logic              search_step;
		logic              shift;
		logic              wr_en;
		logic [IDX_W-1:0]  wr_idx;
		logic [15:0]       wr_id;
		logic [15:0]       wr_cnt;
		logic              touch;
		logic              remove;
		logic              found;
		logic [15:0]       key;
		logic [LIVE_W-1:0] live;
	} itt_cmd_t;

endpackage

`default_nettype wire

>>> design/itt_cell.sv
// ----------------------------------------------------------------------------
// itt_cell
// One table slot: id, idle counter and the match flag of the search chain.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module itt_cell (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic [itt_pkg::IDX_W-1:0] idx,
	input  wire itt_pkg::itt_cmd_t  cmd,
	input  wire itt_pkg::itt_link_t up,
	output itt_pkg::itt_link_t      down
);
	import itt_pkg::*;

	logic [15:0] id_q;
	logic [15:0] cnt_q;
	logic        any_hit_q;
	logic        match;
	logic        top_hit;

	assign match   = (id_q == cmd.key) && (LIVE_W'(idx) < cmd.live);
	// nothing matches above, so a set match here is the highest one
	assign top_hit = !up.any_hit;

	always_ff @(posedge clk) begin
		priority if (cmd.wr_en && (cmd.wr_idx == idx)) begin
			id_q  <= cmd.wr_id;
			cnt_q <= cmd.wr_cnt;
		end else if (cmd.shift || (cmd.remove && cmd.found && top_hit)) begin
			id_q  <= up.id;
			cnt_q <= up.cnt;
		end else if (cmd.touch && match && top_hit) begin
			cnt_q <= '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			any_hit_q <= 1'b0;
		end else if (cmd.search_clr) begin
			any_hit_q <= 1'b0;
		end else if (cmd.search_step) begin
			any_hit_q <= match | up.any_hit;
		end
	end

	assign down = '{id: id_q, cnt: cnt_q, any_hit: any_hit_q};

endmodule

`default_nettype wire

>>> design/idle_timeout_table_core.sv
// ----------------------------------------------------------------------------
// idle_timeout_table_core
// Table of connection ids with idle counters, kept as a chain of slot cells.
//
//  channel  | dir | handshake          | beat
//  in       | in  | in_valid/in_ready  | in_item_t (operation, conn_id)
//  out      | out | out_valid/out_ready| out_item_t (status, id, count, last)
//  apb      | in  | psel/penable/pready| timeout_ticks at offset 0
//
// One item at a time. Touch/remove run a search, the match flag rippling one
// cell per cycle down the chain. Tick rotates the table through cell 0 once.
// Output stalls add cycles only on beats that must be sent. Reset clears the
// entry count; slot contents are not cleared. One output register sits between
// the sequencer and out.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module idle_timeout_table_core (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_ready,
	input  wire itt_pkg::in_item_t in_data,
	output logic                   out_valid,
	input  wire logic              out_ready,
	output itt_pkg::out_item_t     out_data,
	input  wire logic              psel,
	input  wire logic              penable,
	input  wire logic              pwrite,
	input  wire logic [2:0]        paddr,
	input  wire logic [31:0]       pwdata,
	output logic [31:0]            prdata,
	output logic                   pready
);
	import itt_pkg::*;

	localparam logic [2:0] S_IDLE   = 3'd0;
	localparam logic [2:0] S_ADD    = 3'd1;
	localparam logic [2:0] S_SEARCH = 3'd2;
	localparam logic [2:0] S_RESP   = 3'd3;
	localparam logic [2:0] S_TICK   = 3'd4;
	localparam logic [2:0] S_TEND   = 3'd5;

	logic [2:0]        state_q, state_d;
	logic [1:0]        op_q;
	logic [15:0]       key_q;
	logic [LIVE_W-1:0] live_q, live_d;
	logic [LIVE_W-1:0] step_q, step_d;
	logic [15:0]       timeout_q;
	logic              out_valid_q;
	out_item_t         out_q;

	itt_cmd_t          cmd;
	itt_link_t         lnk [DEPTH+1];
	itt_link_t         head;
	logic [15:0]       head_inc;
	logic              due;
	logic              can_load;
	logic              ld;
	out_item_t         ld_item;
	logic              in_acc;

	// cell chain: cell i reads from i+1 and drives lnk[i]
	assign lnk[DEPTH] = '0;
	for (genvar g = 0; g < DEPTH; g++) begin : g_cell
		itt_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.idx    (IDX_W'(g)),
			.cmd    (cmd),
			.up     (lnk[g+1]),
			.down   (lnk[g])
		);
	end

	assign head     = lnk[0];
	assign head_inc = (&head.cnt) ? head.cnt : head.cnt + 16'd1;
	assign due      = head_inc >= timeout_q;

	assign in_ready = (state_q == S_IDLE);
	assign in_acc   = in_valid && in_ready;
	assign can_load = !out_valid_q || out_ready;

	always_comb begin
		state_d = state_q;
		live_d  = live_q;
		step_d  = step_q;
		ld      = 1'b0;
		ld_item = '{status: ST_DONE, result_id: key_q, entries_in_use: '0, last: 1'b1};
		cmd             = '0;
		cmd.key         = key_q;
		cmd.live        = live_q;
		cmd.found       = head.any_hit;
		cmd.wr_id       = head.id;
		cmd.wr_cnt      = head_inc;
		cmd.wr_idx      = IDX_W'(live_q - LIVE_W'(1));

		unique case (state_q)
			S_IDLE: begin
				if (in_acc) begin
					cmd.search_clr = 1'b1;
					step_d = '0;
					unique case (in_data.operation)
						OP_ADD:    state_d = S_ADD;
						OP_TOUCH,
						OP_REMOVE: state_d = S_SEARCH;
						OP_TICK: begin
							state_d = S_TICK;
							step_d  = live_q;  // entries left to visit
						end
						default:   state_d = S_IDLE;
					endcase
				end
			end
			S_ADD: begin
				if (can_load) begin
					ld = 1'b1;
					state_d = S_IDLE;
					if (live_q >= LIVE_W'(DEPTH)) begin
						ld_item.status = ST_FULL;
					end else begin
						cmd.wr_en  = 1'b1;
						cmd.wr_idx = IDX_W'(live_q);
						cmd.wr_id  = key_q;
						cmd.wr_cnt = '0;
						live_d     = live_q + LIVE_W'(1);
					end
					ld_item.entries_in_use = 6'(live_d);
				end
			end
			S_SEARCH: begin
				cmd.search_step = 1'b1;
				step_d = step_q + LIVE_W'(1);
				if (step_q == LIVE_W'(DEPTH - 1)) begin
					state_d = S_RESP;
				end
			end
			S_RESP: begin
				if (can_load) begin
					ld = 1'b1;
					state_d = S_IDLE;
					ld_item.status = head.any_hit ? ST_DONE : ST_NOT_FOUND;
					if (op_q == OP_TOUCH) begin
						cmd.touch = 1'b1;
					end else begin
						cmd.remove = 1'b1;
						if (head.any_hit) begin
							live_d = live_q - LIVE_W'(1);
						end
					end
					ld_item.entries_in_use = 6'(live_d);
				end
			end
			S_TICK: begin
				// rotate: head leaves cell 0, kept entries go back in at the tail
				if (step_q == '0) begin
					state_d = S_TEND;
				end else if (due) begin
					if (can_load) begin
						cmd.shift = 1'b1;
						live_d    = live_q - LIVE_W'(1);
						step_d    = step_q - LIVE_W'(1);
						ld        = 1'b1;
						ld_item   = '{status: ST_EXPIRED, result_id: head.id,
							entries_in_use: 6'(live_d), last: 1'b0};
					end
				end else begin
					cmd.shift = 1'b1;
					cmd.wr_en = 1'b1;
					step_d    = step_q - LIVE_W'(1);
				end
			end
			S_TEND: begin
				if (can_load) begin
					ld      = 1'b1;
					state_d = S_IDLE;
					ld_item = '{status: ST_TICK_DONE, result_id: '0,
						entries_in_use: 6'(live_q), last: 1'b1};
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			live_q      <= '0;
			step_q      <= '0;
			out_valid_q <= 1'b0;
			timeout_q   <= TIMEOUT_RESET;
		end else begin
			state_q <= state_d;
			live_q  <= live_d;
			step_q  <= step_d;
			if (ld) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (psel && penable && pwrite && pready && !paddr[2]) begin
				timeout_q <= pwdata[15:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			op_q  <= in_data.operation;
			key_q <= in_data.conn_id;
		end
		if (ld) begin
			out_q <= ld_item;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;
	assign pready    = 1'b1;
	assign prdata    = paddr[2] ? 32'd0 : {16'd0, timeout_q};

endmodule

`default_nettype wire

>>> design/itt_checker.sv
// ----------------------------------------------------------------------------
// itt_checker
// Port-level checks on the idle timeout table, bound to its top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "idle_timeout_table_core_macros.svh"

module itt_checker (
	input wire logic               clk,
	input wire logic               arst_n,
	input wire logic               in_valid,
	input wire logic               in_ready,
	input wire logic               out_valid,
	input wire logic               out_ready,
	input wire itt_pkg::out_item_t out_data
);
	import itt_pkg::*;

	// a held beat keeps its contents
	`ITT_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(out_data), "out beat changed while stalled")

	// one item at a time: no second accept right after one
	`ITT_ASSERT(a_one_item, in_valid && in_ready |=> !in_ready, "input accepted while busy")

	// only expiry beats lead a multi-beat tick response
	`ITT_ASSERT(a_not_last, out_valid && !out_data.last |-> out_data.status == ST_EXPIRED, "non-final beat is not an expiry")

	`ITT_ASSERT(a_tick_done, out_valid && out_data.status == ST_TICK_DONE |-> out_data.last && out_data.result_id == 16'd0, "bad tick-done beat")

	// out valid is unknown until the first reset edge has cleared it
	`ITT_ASSERT_ALWAYS(a_reset_quiet, !arst_n |=> !out_valid, "out valid during reset")

endmodule

bind idle_timeout_table_core itt_checker u_itt_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.out_data  (out_data)
);

`default_nettype wire

>>> dv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for idle_timeout_table_core. Operations go in through
// the valid/ready input. A behavioral copy of the table and the timeout
// register predicts every output beat, and each beat is checked in order.
// Directed tests cover empty, duplicate, expiry, zero-timeout and full cases.
// Random phases then run under several timeouts, all but one with random stalls.
// ----------------------------------------------------------------------------
module testbench;
	import itt_pkg::*;

	localparam int         IDLE_LIMIT    = 20000;
	localparam int         SETTLE_CYCLES = DEPTH + 8;
	localparam logic [2:0] ADDR_TIMEOUT  = 3'd0;
	localparam logic [2:0] ADDR_UNUSED   = 3'd4;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	in_item_t    in_data = '0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	out_item_t   out_data;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [2:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;

	// behavioral copy of the table and its register
	logic [15:0] slot_ids [DEPTH];
	logic [15:0] slot_idle [DEPTH];
	int          live_entries = 0;
	logic [15:0] timeout_ticks = TIMEOUT_RESET;

	out_item_t   expected_results [$];
	int          error_count = 0;
	int          idle_cycles = 0;
	bit          no_stall = 1'b0;

	idle_timeout_table_core DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready)
	);

	initial begin
		forever #4 clk = ~clk;
	end

	always @(negedge clk) begin
		out_ready <= no_stall || ($urandom_range(99) >= 18);
	end

	function automatic void queue_result(logic [2:0] status, logic [15:0] id, logic last);
		out_item_t beat;
		beat.status         = status;
		beat.result_id      = id;
		beat.entries_in_use = 6'(live_entries);
		beat.last           = last;
		expected_results.push_back(beat);
	endfunction

	function automatic void drop_slot(int pos);
		int i;
		for (i = pos; i + 1 < live_entries; i++) begin
			slot_ids[i]  = slot_ids[i + 1];
			slot_idle[i] = slot_idle[i + 1];
		end
		live_entries--;
	endfunction

	function automatic void predict_table(in_item_t item);
		int          hit;
		int          i;
		logic [15:0] gone;
		hit = -1;
		case (item.operation)
			OP_ADD: begin
				if (live_entries >= DEPTH) begin
					queue_result(ST_FULL, item.conn_id, 1'b1);
				end else begin
					slot_ids[live_entries]  = item.conn_id;
					slot_idle[live_entries] = '0;
					live_entries++;
					queue_result(ST_DONE, item.conn_id, 1'b1);
				end
			end
			OP_TOUCH, OP_REMOVE: begin
				// duplicates: the highest matching slot wins
				for (i = 0; i < live_entries; i++) begin
					if (slot_ids[i] == item.conn_id) hit = i;
				end
				if (hit < 0) begin
					queue_result(ST_NOT_FOUND, item.conn_id, 1'b1);
				end else begin
					if (item.operation == OP_TOUCH) slot_idle[hit] = '0;
					else drop_slot(hit);
					queue_result(ST_DONE, item.conn_id, 1'b1);
				end
			end
			default: begin
				// after an expiry the walk stays on the slot that moved down
				i = 0;
				while (i < live_entries) begin
					if (slot_idle[i] != 16'hFFFF) slot_idle[i]++;
					if (slot_idle[i] >= timeout_ticks) begin
						gone = slot_ids[i];
						drop_slot(i);
						queue_result(ST_EXPIRED, gone, 1'b0);
					end else begin
						i++;
					end
				end
				queue_result(ST_TICK_DONE, '0, 1'b1);
			end
		endcase
	endfunction

	// starts and ends at a falling edge; valid stays up for a following beat
	task automatic send_item(input logic [1:0] op, input logic [15:0] id);
		in_item_t item;
		item.operation = op;
		item.conn_id   = id;
		while (!no_stall && $urandom_range(99) < 18) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		in_data  <= item;
		@(posedge clk);
		while (in_ready !== 1'b1) @(posedge clk);
		predict_table(item);
		@(negedge clk);
	endtask

	// waits for every expected beat, then lets the sequencer go quiet
	task automatic settle_table();
		in_valid <= 1'b0;
		while (expected_results.size() != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic apb_write(input logic [2:0] addr, input logic [15:0] value);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= addr;
		pwdata  <= {16'b0, value};
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (pready !== 1'b1) @(posedge clk);
		if (addr == ADDR_TIMEOUT) timeout_ticks = value;
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		@(negedge clk);
	endtask

	task automatic apb_read_timeout();
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		paddr   <= ADDR_TIMEOUT;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (pready !== 1'b1) @(posedge clk);
		if (prdata !== {16'b0, timeout_ticks}) begin
			error_count++;
			$display("%0t: timeout_ticks read expected %0d, got %0d", $time,
				timeout_ticks, prdata);
		end
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		@(negedge clk);
	endtask

	function automatic logic [15:0] pick_id();
		int r;
		r = $urandom_range(99);
		if (live_entries > 0 && r < 60) return slot_ids[$urandom_range(live_entries - 1)];
		if (r < 85) return 16'($urandom_range(15));
		return 16'($urandom_range(65535));
	endfunction

	task automatic test_reset_state();
		apb_read_timeout();
		send_item(OP_TICK, 16'hFFFF);
		send_item(OP_TOUCH, 16'h0000);
		send_item(OP_REMOVE, 16'hFFFF);
		settle_table();
	endtask

	task automatic test_expiry_order();
		apb_write(ADDR_TIMEOUT, 16'd2);
		send_item(OP_ADD, 16'h0000);
		send_item(OP_ADD, 16'hFFFF);
		send_item(OP_ADD, 16'h0000);
		send_item(OP_ADD, 16'h5A5A);
		send_item(OP_TOUCH, 16'h0000);
		send_item(OP_TICK, 16'h0000);
		send_item(OP_TOUCH, 16'h0000);
		// adjacent slots expire on the same tick
		send_item(OP_TICK, 16'h1234);
		send_item(OP_TOUCH, 16'h1234);
		send_item(OP_REMOVE, 16'hA5A5);
		send_item(OP_REMOVE, 16'h0000);
		settle_table();
		apb_write(ADDR_UNUSED, 16'd0);
		apb_read_timeout();
	endtask

	task automatic test_zero_timeout();
		settle_table();
		apb_write(ADDR_TIMEOUT, 16'd0);
		send_item(OP_ADD, 16'h00FF);
		send_item(OP_ADD, 16'hFF00);
		send_item(OP_TICK, 16'h0000);
		settle_table();
	endtask

	task automatic test_table_full();
		int k;
		apb_write(ADDR_TIMEOUT, 16'hFFFF);
		for (k = 0; k < DEPTH + 2; k++) begin
			send_item(OP_ADD, 16'($urandom_range(65535)));
		end
		send_item(OP_TOUCH, slot_ids[DEPTH - 1]);
		send_item(OP_REMOVE, slot_ids[DEPTH / 2]);
		send_item(OP_ADD, 16'($urandom_range(65535)));
		send_item(OP_ADD, 16'($urandom_range(65535)));
		send_item(OP_TICK, 16'h0000);
		send_item(OP_TICK, 16'hFFFF);
		settle_table();
		// every slot expires on one tick: the longest burst of beats
		apb_write(ADDR_TIMEOUT, 16'd1);
		send_item(OP_TICK, 16'h0000);
		send_item(OP_TICK, 16'h0000);
		settle_table();
	endtask

	task automatic run_random_phase(input logic [15:0] timeout, input int count,
		input bit steady);
		int         n;
		int         r;
		logic [1:0] op;
		settle_table();
		apb_write(ADDR_TIMEOUT, timeout);
		no_stall = steady;
		for (n = 0; n < count; n++) begin
			r = $urandom_range(99);
			if (live_entries < 4 && r < 50) op = OP_ADD;
			else if (r < 35) op = OP_ADD;
			else if (r < 55) op = OP_TOUCH;
			else if (r < 70) op = OP_REMOVE;
			else op = OP_TICK;
			send_item(op, pick_id());
			if (n == count / 2 && !steady) settle_table();
		end
		settle_table();
		no_stall = 1'b0;
	endtask

	task automatic test_random();
		run_random_phase(16'd3, 75, 1'b0);
		run_random_phase(16'd1, 70, 1'b1);
		run_random_phase(16'd8, 75, 1'b0);
		run_random_phase(16'hFFFF, 70, 1'b0);
		run_random_phase(16'($urandom_range(20, 2)), 70, 1'b0);
	endtask

	// result checker
	always @(posedge clk) begin
		out_item_t exp_beat;
		if (arst_n && out_valid === 1'b1 && out_ready) begin
			if (expected_results.size() == 0) begin
				error_count++;
				$display("%0t: beat expected none, got status %0d id %0h count %0d last %0d",
					$time, out_data.status, out_data.result_id,
					out_data.entries_in_use, out_data.last);
			end else begin
				exp_beat = expected_results.pop_front();
				if (out_data !== exp_beat) error_count++;
				if (out_data.status !== exp_beat.status)
					$display("%0t: status expected %0d, got %0d", $time,
						exp_beat.status, out_data.status);
				if (out_data.result_id !== exp_beat.result_id)
					$display("%0t: result_id expected %0h, got %0h", $time,
						exp_beat.result_id, out_data.result_id);
				if (out_data.entries_in_use !== exp_beat.entries_in_use)
					$display("%0t: entries_in_use expected %0d, got %0d", $time,
						exp_beat.entries_in_use, out_data.entries_in_use);
				if (out_data.last !== exp_beat.last)
					$display("%0t: last expected %0d, got %0d", $time,
						exp_beat.last, out_data.last);
			end
		end
	end

	// watchdog: too long without any beat or register access
	always @(posedge clk) begin
		if ((in_valid && in_ready === 1'b1) || (out_valid === 1'b1 && out_ready)
			|| (psel && penable)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= IDLE_LIMIT) begin
			$display("simulation failed");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	initial begin
		repeat (8) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		test_reset_state();
		test_expiry_order();
		test_zero_timeout();
		test_table_full();
		test_random();
		settle_table();
		if (error_count == 0 && expected_results.size() == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

endmodule

>>> idle_timeout_table_core.f
+incdir+design
design/itt_pkg.sv
design/itt_cell.sv
design/idle_timeout_table_core.sv
design/itt_checker.sv
dv/testbench.sv
